FILE: hw/rtl/srm_pkg.sv
// ----------------------------------------------------------------------------
// Running median package
// Shared types and constants of the stream running median unit.
// ----------------------------------------------------------------------------
package srm_pkg;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_CHECK  = 12'b000000000010,
		ST_ROOTRD = 12'b000000000100,
		ST_ROOTWT = 12'b000000001000,
		ST_UPRD   = 12'b000000010000,
		ST_UPWT   = 12'b000000100000,
		ST_UPCMP  = 12'b000001000000,
		ST_DNRD   = 12'b000010000000,
		ST_DNWT   = 12'b000100000000,
		ST_DNCMP  = 12'b001000000000,
		ST_MEDRD  = 12'b010000000000,
		ST_OUT    = 12'b100000000000
	} state_t;

endpackage

FILE: hw/rtl/stream_running_median_unit.sv
// ----------------------------------------------------------------------------
// Stream running median unit
// Keeps a max-heap of the lower half and a min-heap of the upper half of a
// stream of signed samples and reports the floor of the running median.
// ----------------------------------------------------------------------------
// The input channel carries a sample and a restart flag; restart empties both
// heaps before the sample is inserted. The output channel carries one request
// per input request: the floor of the median and a dropped flag, set when both
// heaps were full and the sample was discarded.
// The unit takes one request at a time and holds in_stall high while it works.
// A request is taken only in the idle state. The unit checks the counts and
// reads both roots, then walks the heaps: a sift-up and, when a root moves to
// the other heap, a sift-down, each walking one heap level at a time through
// the heap memories with a single read-compare-write step. A dropped sample
// skips both walks. Last the unit reads the roots and loads the result, then
// returns to idle and can take the next request.
// The result sits in an output register; the next sample is taken while it
// waits, but the unit finishes that sample only after the result is taken.
// Reset clears both heap counts and empties the output register. The heap
// memories are not cleared; only entries below the counts are ever used.
// ----------------------------------------------------------------------------
module stream_running_median_unit #(
	parameter int HALF_CAPACITY = 512,
	parameter int SAMPLE_WIDTH  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] median,
	output logic                           dropped
);

	import srm_pkg::*;

	localparam int AW = $clog2(HALF_CAPACITY);
	localparam int CW = $clog2(HALF_CAPACITY + 1);

	state_t                  state_q;
	logic [CW-1:0]           lcnt_q, ucnt_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q, med_q, val_q;
	logic                    drop_q;
	logic                    is_max_q;
	logic                    then_down_q;
	logic [CW-1:0]           pos_q, limit_q;
	logic                    ovalid_q;

	logic                    l_we, u_we;
	logic [AW-1:0]           l_wa, u_wa, l_ra, l_rb, u_ra, u_rb;
	logic [SAMPLE_WIDTH-1:0] l_wd, u_wd, l_da, l_db, u_da, u_db;

	srm_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HALF_CAPACITY)) u_lower (
		.clk, .we(l_we), .waddr(l_wa), .wdata(l_wd),
		.raddr_a(l_ra), .rdata_a(l_da), .raddr_b(l_rb), .rdata_b(l_db)
	);
	srm_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HALF_CAPACITY)) u_upper (
		.clk, .we(u_we), .waddr(u_wa), .wdata(u_wd),
		.raddr_a(u_ra), .rdata_a(u_da), .raddr_b(u_rb), .rdata_b(u_db)
	);

	logic [CW-1:0]  parent, lch, rch;
	logic [CW:0]    lch_w;
	logic signed [SAMPLE_WIDTH-1:0] ra, rb;
	logic           l_ok, r_ok, ab_a, ab_b, b_over_a, up_sw;
	logic signed [SAMPLE_WIDTH:0] msum;
	logic           in_acc;
	logic           out_load;

	assign parent = (pos_q - CW'(1)) >> 1;
	assign lch_w  = {pos_q, 1'b1};
	assign lch    = lch_w[CW-1:0];
	assign rch    = lch + CW'(1);
	assign l_ok   = ({1'b0, lch_w} < {2'b0, limit_q});
	assign r_ok   = ({1'b0, lch_w} + (CW+2)'(1)) < {2'b0, limit_q};
	assign ra     = is_max_q ? l_da : u_da;
	assign rb     = is_max_q ? l_db : u_db;

	function automatic logic above(input logic mx, input logic signed [SAMPLE_WIDTH-1:0] a,
			input logic signed [SAMPLE_WIDTH-1:0] b);
		above = mx ? (a > b) : (a < b);
	endfunction

	assign ab_a     = above(is_max_q, ra, val_q);
	assign b_over_a = ab_a ? above(is_max_q, rb, ra) : above(is_max_q, rb, val_q);
	assign up_sw    = above(is_max_q, val_q, ra);
	assign msum     = {l_da[SAMPLE_WIDTH-1], l_da} + {u_da[SAMPLE_WIDTH-1], u_da};
	assign ab_b     = b_over_a;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_valid = ovalid_q;
	assign out_load = (state_q == ST_OUT) && (!ovalid_q || !out_stall);

	always_comb begin
		l_we = 1'b0; u_we = 1'b0;
		l_wa = '0; u_wa = '0;
		l_wd = val_q; u_wd = val_q;
		l_ra = '0; l_rb = '0; u_ra = '0; u_rb = '0;
		case (state_q)
			ST_ROOTRD: begin
				l_ra = '0; u_ra = '0;
			end
			ST_UPRD, ST_UPWT: begin
				l_ra = parent[AW-1:0]; u_ra = parent[AW-1:0];
			end
			ST_UPCMP: begin
				l_we = is_max_q; u_we = !is_max_q;
				l_wa = pos_q[AW-1:0]; u_wa = pos_q[AW-1:0];
				if (pos_q != '0 && up_sw) begin
					l_wd = ra; u_wd = ra;
				end
			end
			ST_DNRD, ST_DNWT: begin
				l_ra = lch[AW-1:0]; u_ra = lch[AW-1:0];
				l_rb = rch[AW-1:0]; u_rb = rch[AW-1:0];
			end
			ST_DNCMP: begin
				l_we = is_max_q; u_we = !is_max_q;
				l_wa = pos_q[AW-1:0]; u_wa = pos_q[AW-1:0];
				if (r_ok && ab_b) begin
					l_wd = rb; u_wd = rb;
				end else if (l_ok && ab_a) begin
					l_wd = ra; u_wd = ra;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			lcnt_q   <= '0;
			ucnt_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						x_q     <= sample;
						drop_q  <= 1'b0;
						if (restart) begin
							lcnt_q <= '0;
							ucnt_q <= '0;
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					then_down_q <= 1'b0;
					if (lcnt_q == CW'(HALF_CAPACITY) && ucnt_q == CW'(HALF_CAPACITY)) begin
						drop_q  <= 1'b1;
						state_q <= ST_MEDRD;
					end else if (lcnt_q == '0 && ucnt_q == '0) begin
						is_max_q <= 1'b1;
						val_q    <= x_q;
						pos_q    <= '0;
						state_q  <= ST_UPCMP;
						lcnt_q   <= CW'(1);
					end else begin
						state_q <= ST_ROOTWT;
					end
				end
				ST_ROOTWT: begin
					if (x_q > med_q) begin
						if (ucnt_q > lcnt_q) begin
							is_max_q <= 1'b1; val_q <= u_da; pos_q <= lcnt_q;
							lcnt_q <= lcnt_q + CW'(1); then_down_q <= 1'b1;
						end else begin
							is_max_q <= 1'b0; val_q <= x_q; pos_q <= ucnt_q;
							ucnt_q <= ucnt_q + CW'(1);
						end
					end else begin
						if (lcnt_q > ucnt_q) begin
							is_max_q <= 1'b0; val_q <= l_da; pos_q <= ucnt_q;
							ucnt_q <= ucnt_q + CW'(1); then_down_q <= 1'b1;
						end else begin
							is_max_q <= 1'b1; val_q <= x_q; pos_q <= lcnt_q;
							lcnt_q <= lcnt_q + CW'(1);
						end
					end
					state_q <= ST_UPRD;
				end
				ST_UPRD: begin
					state_q <= (pos_q == '0) ? ST_UPCMP : ST_UPWT;
				end
				ST_UPWT: begin
					state_q <= ST_UPCMP;
				end
				ST_UPCMP: begin
					if (pos_q != '0 && up_sw) begin
						pos_q   <= parent;
						state_q <= ST_UPRD;
					end else if (then_down_q) begin
						then_down_q <= 1'b0;
						is_max_q <= !is_max_q;
						val_q    <= x_q;
						pos_q    <= '0;
						limit_q  <= is_max_q ? ucnt_q : lcnt_q;
						state_q  <= ST_DNRD;
					end else begin
						state_q <= ST_MEDRD;
					end
				end
				ST_DNRD: begin
					state_q <= ST_DNWT;
				end
				ST_DNWT: begin
					state_q <= ST_DNCMP;
				end
				ST_DNCMP: begin
					if (r_ok && ab_b) begin
						pos_q   <= rch;
						state_q <= ST_DNRD;
					end else if (l_ok && ab_a) begin
						pos_q   <= lch;
						state_q <= ST_DNRD;
					end else begin
						state_q <= ST_MEDRD;
					end
				end
				ST_MEDRD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						if (lcnt_q == '0 && ucnt_q == '0) begin
							med_q <= '0;
						end else if (lcnt_q > ucnt_q) begin
							med_q <= l_da;
						end else if (ucnt_q > lcnt_q) begin
							med_q <= u_da;
						end else begin
							med_q <= msum[SAMPLE_WIDTH:1];
						end
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dropped <= drop_q;
		end
	end

	assign median = med_q;

endmodule

FILE: hw/rtl/srm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, two registered read ports.
// ----------------------------------------------------------------------------
module srm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: dv/stream_running_median_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream running median unit testbench
// Drives signed samples with random restarts and idle gaps, stalls the result
// side at random and once for a long stretch, and checks every result against
// a table for the directed rows and otherwise against a two-heap running median.
// ----------------------------------------------------------------------------
module stream_running_median_unit_tb;

	localparam int HALF = 512;
	localparam int SW = 32;
	localparam int DIRECTED = 14;
	localparam int RANDOM_ITEMS = 506;

	typedef struct {
		logic signed [SW-1:0] sample;
		logic                 restart;
		logic                 known;
		logic signed [SW-1:0] median;
		logic                 dropped;
	} row_t;

	typedef struct {
		logic signed [SW-1:0] median;
		logic                 dropped;
	} result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [SW-1:0] sample;
	logic                 restart;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [SW-1:0] median;
	logic                 dropped;

	longint lo_heap[HALF];
	longint hi_heap[HALF];
	int     lo_n;
	int     hi_n;

	result_t medians_due[$];
	row_t    rows[DIRECTED];
	int      mismatches;
	bit      long_hold;
	bit      stim_done;
	int      fill_count;

	stream_running_median_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample(sample), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.median(median), .dropped(dropped)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic bit ranks_above(bit is_max, longint a, longint b);
		return is_max ? (a > b) : (a < b);
	endfunction

	task automatic heap_up(ref longint h[HALF], input bit is_max, input int pos);
		int     parent;
		longint t;
		while (pos > 0) begin
			parent = (pos - 1) / 2;
			if (!ranks_above(is_max, h[pos], h[parent]))
				break;
			t = h[pos];
			h[pos] = h[parent];
			h[parent] = t;
			pos = parent;
		end
	endtask

	task automatic heap_down(ref longint h[HALF], input bit is_max, input int cnt);
		int     pos;
		int     best;
		longint t;
		pos = 0;
		forever begin
			best = pos;
			if (2 * pos + 1 < cnt && ranks_above(is_max, h[2 * pos + 1], h[best]))
				best = 2 * pos + 1;
			if (2 * pos + 2 < cnt && ranks_above(is_max, h[2 * pos + 2], h[best]))
				best = 2 * pos + 2;
			if (best == pos)
				break;
			t = h[pos];
			h[pos] = h[best];
			h[best] = t;
			pos = best;
		end
	endtask

	function automatic longint floor_median();
		longint s;
		if (lo_n == 0 && hi_n == 0)
			return 0;
		if (lo_n > hi_n)
			return lo_heap[0];
		if (hi_n > lo_n)
			return hi_heap[0];
		s = lo_heap[0] + hi_heap[0];
		return (s - (s & 1)) / 2;
	endfunction

	task automatic insert_sample(input logic signed [SW-1:0] smp, input logic rst,
			output result_t res);
		longint x;
		x = smp;
		res.dropped = 1'b0;
		if (rst) begin
			lo_n = 0;
			hi_n = 0;
		end
		if (lo_n >= HALF && hi_n >= HALF) begin
			res.dropped = 1'b1;
		end else if (lo_n == 0 && hi_n == 0) begin
			lo_heap[0] = x;
			lo_n = 1;
		end else if (x > floor_median()) begin
			if (hi_n > lo_n) begin
				lo_heap[lo_n] = hi_heap[0];
				heap_up(lo_heap, 1'b1, lo_n);
				lo_n++;
				hi_heap[0] = x;
				heap_down(hi_heap, 1'b0, hi_n);
			end else begin
				hi_heap[hi_n] = x;
				heap_up(hi_heap, 1'b0, hi_n);
				hi_n++;
			end
		end else begin
			if (lo_n > hi_n) begin
				hi_heap[hi_n] = lo_heap[0];
				heap_up(hi_heap, 1'b0, hi_n);
				hi_n++;
				lo_heap[0] = x;
				heap_down(lo_heap, 1'b1, lo_n);
			end else begin
				lo_heap[lo_n] = x;
				heap_up(lo_heap, 1'b1, lo_n);
				lo_n++;
			end
		end
		res.median = SW'(floor_median());
	endtask

	function automatic bit idle_now(int k);
		if (k >= 300 && k < 700)
			return 1'b0;
		return $urandom_range(99) < 11;
	endfunction

	task automatic send_request(input logic signed [SW-1:0] smp, input logic rst,
			input int k, input row_t r, input bit has_row);
		result_t res;
		while (idle_now(k)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= smp;
		restart <= rst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		insert_sample(smp, rst, res);
		if (has_row && r.known) begin
			res.median = r.median;
			res.dropped = r.dropped;
		end
		medians_due.insert(medians_due.size(), res);
	endtask

	function automatic logic signed [SW-1:0] rand_sample();
		case ($urandom_range(5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(20)) - 10;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		row_t   r;
		int     k;
		logic   rst;
		in_valid = 1'b0;
		sample = '0;
		restart = 1'b0;
		arst_n = 1'b0;
		mismatches = 0;
		stim_done = 1'b0;
		lo_n = 0;
		hi_n = 0;
		rows[0]  = '{32'sd5, 1'b0, 1'b1, 32'sd5, 1'b0};
		rows[1]  = '{32'sd8, 1'b0, 1'b1, 32'sd6, 1'b0};
		rows[2]  = '{-32'sd3, 1'b0, 1'b1, 32'sd5, 1'b0};
		rows[3]  = '{-32'sd4, 1'b1, 1'b1, -32'sd4, 1'b0};
		rows[4]  = '{-32'sd1, 1'b0, 1'b1, -32'sd3, 1'b0};
		rows[5]  = '{32'sh7FFFFFFF, 1'b1, 1'b1, 32'sh7FFFFFFF, 1'b0};
		rows[6]  = '{32'sh7FFFFFFF, 1'b0, 1'b1, 32'sh7FFFFFFF, 1'b0};
		rows[7]  = '{32'sh80000000, 1'b1, 1'b1, 32'sh80000000, 1'b0};
		rows[8]  = '{32'sh80000000, 1'b0, 1'b1, 32'sh80000000, 1'b0};
		rows[9]  = '{32'sh7FFFFFFF, 1'b1, 1'b1, 32'sh7FFFFFFF, 1'b0};
		rows[10] = '{32'sh80000000, 1'b0, 1'b1, -32'sd1, 1'b0};
		rows[11] = '{32'sd0, 1'b0, 1'b0, 32'sd0, 1'b0};
		rows[12] = '{32'sd1, 1'b0, 1'b0, 32'sd0, 1'b0};
		rows[13] = '{-32'sd2, 1'b0, 1'b0, 32'sd0, 1'b0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (k = 0; k < DIRECTED; k++)
			send_request(rows[k].sample, rows[k].restart, k, rows[k], 1'b1);
		// Fill both heaps to capacity and push past it to hit the dropped path.
		fill_count = 2 * HALF + 6;
		for (k = 0; k < fill_count; k++)
			send_request(rand_sample(), k == 0, 1000, r, 1'b0);
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			rst = ($urandom_range(99) < 3);
			send_request(rand_sample(), rst, k, r, 1'b0);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Long hold on the result side so the unit backs up and stalls its input.
	initial begin
		long_hold = 1'b0;
		wait (arst_n);
		repeat (400) @(posedge clk);
		long_hold = 1'b1;
		repeat (600) @(posedge clk);
		long_hold = 1'b0;
	end

	initial begin
		int cyc;
		out_stall = 1'b0;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			out_stall <= long_hold || (!(cyc >= 2000 && cyc < 4000) &&
				$urandom_range(99) < 11);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (medians_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result median=%0d dropped=%0b", median, dropped);
			end else begin
				want = medians_due.pop_front();
				if (median !== want.median || dropped !== want.dropped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: median exp %0d got %0d, dropped exp %0b got %0b",
							want.median, median, want.dropped, dropped);
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		while (medians_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/srm_pkg.sv
hw/rtl/srm_ram.sv
hw/rtl/stream_running_median_unit.sv
dv/stream_running_median_unit_tb.sv
